// File: rtl/l2h_pkg.sv
// ----------------------------------------------------------------------------
// l2h_pkg
// Shared widths, request codes and the bin selection function of the
// power-of-two latency histogram.
// ----------------------------------------------------------------------------
package l2h_pkg;

  localparam int DATA_W       = 32;
  localparam int BIN_W        = 5;
  localparam int LEN_W        = 6;
  localparam int NUM_BINS_DEF = 16;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // bit length of the sample, at least one; zero when past the top bin
  function automatic logic [BIN_W-1:0] bin_of(input logic [DATA_W-1:0] value,
                                              input logic [LEN_W-1:0]  nbins);
    logic [LEN_W-1:0] len;
    len = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (value[i]) begin
        len = LEN_W'(i + 1);
      end
    end
    if (len == '0) begin
      len = LEN_W'(1);
    end
    if (len > nbins) begin
      return '0;
    end
    return len[BIN_W-1:0];
  endfunction

endpackage

// File: rtl/log2_latency_histogram.sv
// ----------------------------------------------------------------------------
// log2_latency_histogram
// Power-of-two histogram: counters held in a synchronous memory,
// read-modify-write with forwarding of the last write.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid / in_stall | req_type, sample_value, read_bin
//   out     | output    | out_valid/out_stall | bin_hit, bin_count
//
// One word per cycle while the output is not stalled. A taken word has its
// memory read on the taking edge into the middle stage, then increment, write
// back and output register.
// Back-to-back adds to one bin are served by forwarding the last write.
// Reset clears the per-entry valid bits at once, so no clearing pass is run.
// A stalled output holds its word; the middle stage then holds and in_stall
// rises.
// ----------------------------------------------------------------------------
module log2_latency_histogram #(
  parameter int NUM_BINS = l2h_pkg::NUM_BINS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       req_type,
  input  logic [l2h_pkg::DATA_W-1:0] sample_value,
  input  logic [l2h_pkg::BIN_W-1:0]  read_bin,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [l2h_pkg::BIN_W-1:0]  bin_hit,
  output logic [l2h_pkg::DATA_W-1:0] bin_count
);
  import l2h_pkg::*;

  localparam int DEPTH = NUM_BINS + 1;
  localparam int AW    = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;

  logic              in_acc;
  logic [BIN_W-1:0]  in_bin;
  logic              in_oob;

  logic              s1_valid;
  logic              s1_add;
  logic [BIN_W-1:0]  s1_bin;
  logic [AW-1:0]     s1_addr;
  logic              s1_oob;
  logic              s1_adv;

  logic [DATA_W-1:0] rd_data;
  logic              rd_vld;

  logic              last_vld;
  logic [AW-1:0]     last_addr;
  logic [DATA_W-1:0] last_data;

  logic [DATA_W-1:0] cur;
  logic [DATA_W-1:0] sum;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign in_oob = (req_type == REQ_READ) && ({1'b0, read_bin} > LEN_W'(NUM_BINS));
  assign in_bin = (req_type == REQ_ADD) ? bin_of(sample_value, LEN_W'(NUM_BINS)) : read_bin;

  always_comb begin
    if (last_vld && (last_addr == s1_addr)) begin
      cur = last_data;
    end else if (rd_vld) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
    sum = cur + DATA_W'(1);
  end

  // counter memory
  always_ff @(posedge clk) begin
    if (in_acc && !in_oob) begin
      rd_data <= mem[in_bin[AW-1:0]];
    end
    if (s1_adv && s1_add) begin
      mem[s1_addr] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld   <= 1'b0;
      last_vld <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_vld <= !in_oob && vld[in_bin[AW-1:0]];
      end
      if (s1_adv && s1_add) begin
        vld[s1_addr] <= 1'b1;
        last_vld     <= 1'b1;
      end
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_add  <= (req_type == REQ_ADD);
      s1_bin  <= in_bin;
      s1_addr <= in_bin[AW-1:0];
      s1_oob  <= in_oob;
    end
    if (s1_adv && s1_add) begin
      last_addr <= s1_addr;
      last_data <= sum;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      bin_hit <= s1_bin;
      if (s1_oob) begin
        bin_count <= '0;
      end else if (s1_add) begin
        bin_count <= sum;
      end else begin
        bin_count <= cur;
      end
    end
  end

  a_add_logs_write: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_add |=> last_vld && last_addr == $past(s1_addr))
    else $error("add did not record its write-back");

  a_add_result_matches_write: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_add |=> out_valid && bin_count == last_data)
    else $error("add result differs from written count");

  a_oob_read_zero: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_oob |=> out_valid && bin_count == '0)
    else $error("read of missing bin gave a non-zero count");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid && $stable(s1_addr) && $stable(rd_data))
    else $error("middle stage changed while held");

endmodule

// File: test/log2_latency_histogram_test.sv
// ----------------------------------------------------------------------------
// log2_latency_histogram_test
// Self-checking bench for the power-of-two histogram. Words are queued by a
// stimulus process and fed through valid/stall by a clocked driver. Every
// accepted add updates a local set of bin counters; the expected result of
// each word is queued. A clocked monitor compares each result word, field by
// field, with the oldest queued result. Directed edge cases come first, then
// random adds, reads and same-bin bursts under changing sender and receiver
// idling, and a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module log2_latency_histogram_test;
  timeunit 1ns;
  timeprecision 1ps;

  import l2h_pkg::*;

  localparam int NUM_BINS = NUM_BINS_DEF;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] sample;
    logic [BIN_W-1:0]  bin;
  } hist_req_t;

  typedef struct packed {
    logic [BIN_W-1:0]  bin;
    logic [DATA_W-1:0] count;
  } hist_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              req_type = REQ_ADD;
  logic [DATA_W-1:0] sample_value = '0;
  logic [BIN_W-1:0]  read_bin = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BIN_W-1:0]  bin_hit;
  logic [DATA_W-1:0] bin_count;

  hist_req_t         word_queue[$];
  hist_res_t         expected_bins[$];
  logic [DATA_W-1:0] bin_totals[0:NUM_BINS];
  hist_req_t         next_word;
  hist_res_t         want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  int errors = 0;
  int adds_seen = 0;
  int reads_seen = 0;
  int backed_up_cycles = 0;

  log2_latency_histogram #(
    .NUM_BINS(NUM_BINS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .sample_value(sample_value),
    .read_bin(read_bin),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .bin_hit(bin_hit),
    .bin_count(bin_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // top set bit position, floored at bin one, overflow past the top bin
  function automatic logic [BIN_W-1:0] sample_bin(input logic [DATA_W-1:0] v);
    int msb;
    msb = 0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (v[i] && msb == 0) begin
        msb = i + 1;
      end
    end
    if (msb < 1) begin
      msb = 1;
    end
    if (msb > NUM_BINS) begin
      return '0;
    end
    return BIN_W'(msb);
  endfunction

  function automatic void predict_bin_result(input hist_req_t w);
    hist_res_t r;
    if (w.kind == REQ_ADD) begin
      r.bin = sample_bin(w.sample);
      bin_totals[r.bin] = bin_totals[r.bin] + 1'b1;
      r.count = bin_totals[r.bin];
      adds_seen++;
    end else begin
      r.bin = w.bin;
      r.count = (w.bin <= NUM_BINS) ? bin_totals[w.bin] : '0;
      reads_seen++;
    end
    expected_bins.push_back(r);
  endfunction

  function automatic logic [DATA_W-1:0] sample_of_length(input int len);
    logic [63:0] base;
    if (len == 0) begin
      return '0;
    end
    base = 64'd1 << (len - 1);
    return DATA_W'(base | ({32'd0, $urandom} & (base - 1)));
  endfunction

  task automatic push_add(input logic [DATA_W-1:0] v, input logic [BIN_W-1:0] junk);
    word_queue.push_back('{kind: REQ_ADD, sample: v, bin: junk});
  endtask

  task automatic push_read(input logic [BIN_W-1:0] b, input logic [DATA_W-1:0] junk);
    word_queue.push_back('{kind: REQ_READ, sample: junk, bin: b});
  endtask

  task automatic push_random(input int n);
    int pushed;
    int pick;
    int len;
    logic [DATA_W-1:0] v;
    pushed = 0;
    while (pushed < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_add(sample_of_length($urandom_range(32)), BIN_W'($urandom));
        pushed++;
      end else if (pick < 63) begin
        push_add($urandom, BIN_W'($urandom));
        pushed++;
      end else if (pick < 73) begin
        // run of adds to one bin, then read it back at once
        len = $urandom_range(32);
        repeat ($urandom_range(5, 2)) begin
          v = sample_of_length(len);
          push_add(v, BIN_W'($urandom));
          pushed++;
        end
        push_read(sample_bin(v), $urandom);
        pushed++;
      end else if (pick < 93) begin
        push_read(BIN_W'($urandom_range(NUM_BINS)), $urandom);
        pushed++;
      end else begin
        push_read(BIN_W'($urandom), $urandom);
        pushed++;
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (word_queue.size() != 0 || in_valid || expected_bins.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = word_queue.pop_front();
        in_valid <= 1'b1;
        req_type <= next_word.kind;
        sample_value <= next_word.sample;
        read_bin <= next_word.bin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_bin_result('{kind: req_type, sample: sample_value, bin: read_bin});
    end
    if (!rst && in_valid && in_stall) begin
      backed_up_cycles++;
    end
  end

  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bins.size() == 0) begin
        $display("%0t: result word with nothing expected, bin_hit %0d bin_count %0d",
                 $time, bin_hit, bin_count);
        errors++;
      end else begin
        want = expected_bins.pop_front();
        if (bin_hit !== want.bin) begin
          $display("%0t: bin_hit expected %0d actual %0d", $time, want.bin, bin_hit);
          errors++;
        end
        if (bin_count !== want.count) begin
          $display("%0t: bin_count expected %0d actual %0d", $time, want.count, bin_count);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i <= NUM_BINS; i++) begin
      bin_totals[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_add(32'd0, 5'd0);
    push_add(32'd1, 5'd0);
    push_add(32'd2, 5'd0);
    push_add(32'd3, 5'd0);
    push_add(32'd4, 5'd0);
    push_add(32'h0000_7fff, 5'd0);
    push_add(32'h0000_8000, 5'd0);
    push_add(32'h0000_ffff, 5'd0);
    push_add(32'h0001_0000, 5'd0);
    push_add(32'h8000_0000, 5'd0);
    push_add(32'hffff_ffff, 5'h1f);
    push_read(5'd0, 32'd0);
    push_read(5'd1, 32'hffff_ffff);
    push_read(5'd2, 32'd0);
    push_read(5'd16, 32'd0);
    push_read(5'd17, 32'd0);
    push_read(5'd31, 32'd0);
    push_read(5'd15, 32'd0);
    push_add(32'd5, 5'd0);
    push_add(32'd6, 5'd0);
    push_add(32'd7, 5'd0);
    push_read(5'd3, 32'd0);
    wait_drained();

    send_idle_pct = 19;
    recv_idle_pct = 85;
    push_random(620);
    wait_drained();

    send_idle_pct = 85;
    recv_idle_pct = 19;
    push_random(620);
    wait_drained();

    // long receiver hold-off with the sender pushing flat out
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(80);
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;
    wait_drained();

    push_random(610);
    wait_drained();
    repeat (8) @(negedge clk);

    $display("ran %0d adds and %0d reads, edge samples, unused bins and same-bin runs",
             adds_seen, reads_seen);
    $display("input held off by the block for %0d cycles", backed_up_cycles);
    errors += expected_bins.size();
    if (errors == 0) begin
      $display("log2_latency_histogram_test OK");
    end else begin
      $display("log2_latency_histogram_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words still queued", word_queue.size());
    $display("log2_latency_histogram_test NOT OK");
    $finish;
  end

endmodule
